// ===== design/cspt_pkg.sv =====
// ----------------------------------------------------------------------------
// cspt_pkg
// Shared types and constants for the channel slew position table.
// ----------------------------------------------------------------------------
package cspt_pkg;

    localparam int POS_W   = 16;
    localparam int IDX_W   = 4;
    localparam int CHAN_W  = 8;
    localparam int STEP_W  = 15;
    localparam int ASTEP_W = 12;

    // floor(x / 5) = (x * 0xCCCD) >> 18 for x below 2**16
    localparam logic [15:0] DIV5_MUL   = 16'hCCCD;
    localparam int          DIV5_SHIFT = 18;

    typedef enum logic [2:0] {
        CMD_SET_CUR  = 3'd0,
        CMD_SET_TGT  = 3'd1,
        CMD_SET_CHAN = 3'd2,
        CMD_AUTO     = 3'd3,
        CMD_MANUAL   = 3'd4,
        CMD_IDX_DAMP = 3'd5
    } command_t;

    typedef struct packed {
        logic                     tok;
        command_t                 cmd;
        logic [IDX_W-1:0]         index;
        logic signed [POS_W-1:0]  value;
        logic [CHAN_W-1:0]        chan;
        logic [STEP_W-1:0]        step;
    } chain_word_t;

    typedef struct packed {
        logic                     valid;
        logic [IDX_W-1:0]         index;
        logic signed [POS_W-1:0]  position;
        logic                     at_target;
        logic                     hit;
        logic                     last;
    } result_t;

endpackage

// ===== design/channel_slew_position_table.sv =====
// ----------------------------------------------------------------------------
// channel_slew_position_table
// Table of slew-limited positions, one cell per entry in a chain.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low. The word then
// walks the chain of entry cells, one cell per cycle; busy stays high until
// it has left the last cell, and only then can a new one be taken. Channel
// damps give one result per entry on consecutive cycles, the first one from
// cell 0; set and indexed damp give a single result when the word reaches
// the addressed cell. Each result passes the output register, shows for one
// cycle with result_valid and cannot be held off.
module channel_slew_position_table #(
    parameter int ENTRIES = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [2:0]                             command,
    input  logic [cspt_pkg::IDX_W-1:0]             entry_index,
    input  logic signed [cspt_pkg::POS_W-1:0]      position_value,
    input  logic [cspt_pkg::CHAN_W-1:0]            channel_id,
    input  logic [cspt_pkg::STEP_W-1:0]            step_size,
    output logic                                   result_valid,
    output logic [cspt_pkg::IDX_W-1:0]             out_index,
    output logic signed [cspt_pkg::POS_W-1:0]      out_position,
    output logic                                   at_target,
    output logic                                   channel_hit,
    output logic                                   last
);
    import cspt_pkg::*;

    chain_word_t          chain [ENTRIES+1];
    result_t              res   [ENTRIES];
    logic [ENTRIES-1:0]   tok_vec;
    result_t              pick;
    result_t              out_reg;
    logic                 valid_reg;
    logic                 accept;

    assign accept = start && !busy;

    always_comb
    begin
        chain[0].tok   = accept;
        chain[0].cmd   = command_t'(command);
        chain[0].index = entry_index;
        chain[0].value = position_value;
        chain[0].chan  = channel_id;
        chain[0].step  = step_size;
    end

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_cell
            cspt_cell #(
                .CELL_INDEX (g),
                .IS_LAST    (g == ENTRIES - 1)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .word_in  (chain[g]),
                .word_out (chain[g+1]),
                .result   (res[g])
            );
            assign tok_vec[g] = chain[g+1].tok;
        end
    endgenerate

    assign busy = |tok_vec;

    // at most one cell acts per cycle
    always_comb
    begin
        pick = '0;
        for (int k = 0; k < ENTRIES; k++)
        begin
            if (res[k].valid)
            begin
                pick = result_t'(pick | res[k]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= pick.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= pick;
    end

    assign result_valid = valid_reg;
    assign out_index    = out_reg.index;
    assign out_position = out_reg.position;
    assign at_target    = out_reg.at_target;
    assign channel_hit  = out_reg.hit;
    assign last         = out_reg.last;

    a_token_single: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_vec))
        else $error("more than one command word in the chain");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted word did not enter the chain");

    a_result_in_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result word without a command in flight");

endmodule

// ===== design/cspt_cell.sv =====
// ----------------------------------------------------------------------------
// cspt_cell
// One table entry: holds position, target and tag, acts on the command word
// while it passes, and hands the word on to the next cell.
// ----------------------------------------------------------------------------
module cspt_cell #(
    parameter int CELL_INDEX = 0,
    parameter bit IS_LAST    = 1'b0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cspt_pkg::chain_word_t word_in,
    output cspt_pkg::chain_word_t word_out,
    output cspt_pkg::result_t     result
);
    import cspt_pkg::*;

    chain_word_t              word_reg;
    logic signed [POS_W-1:0]  cur_reg, cur_next;
    logic signed [POS_W-1:0]  tgt_reg, tgt_next;
    logic [CHAN_W-1:0]        tag_reg, tag_next;
    logic [ASTEP_W-1:0]       astep_reg, astep_next;

    logic signed [POS_W:0]    diff;
    logic [POS_W-1:0]         abs_diff;
    logic [31:0]              prod;
    logic signed [POS_W:0]    stp;
    logic signed [POS_W-1:0]  moved;
    logic                     idx_match;
    logic                     emit;
    logic                     hit;
    logic                     sweep;

    // auto step from stored positions, registered: it follows any change in the next cycle
    always_comb
    begin
        diff       = {tgt_reg[POS_W-1], tgt_reg} - {cur_reg[POS_W-1], cur_reg};
        abs_diff   = diff[POS_W] ? POS_W'(-diff) : diff[POS_W-1:0];
        prod       = 32'(abs_diff >> 2) * 32'(DIV5_MUL);
        astep_next = ASTEP_W'(prod >> DIV5_SHIFT) + ASTEP_W'(1);
    end

    always_comb
    begin
        if (word_reg.cmd == CMD_AUTO)
        begin
            stp = (POS_W+1)'(astep_reg);
        end
        else
        begin
            stp = (POS_W+1)'(word_reg.step);
        end
        if (diff > stp)
        begin
            moved = cur_reg + stp[POS_W-1:0];
        end
        else if (diff < -stp)
        begin
            moved = cur_reg - stp[POS_W-1:0];
        end
        else
        begin
            moved = tgt_reg;
        end
    end

    always_comb
    begin
        idx_match = (int'(word_reg.index) == CELL_INDEX);
        cur_next  = cur_reg;
        tgt_next  = tgt_reg;
        tag_next  = tag_reg;
        emit      = 1'b0;
        hit       = 1'b0;
        sweep     = 1'b0;
        case (word_reg.cmd)
            CMD_SET_CUR:
            begin
                emit = idx_match;
                hit  = idx_match;
                if (idx_match)
                begin
                    cur_next = word_reg.value;
                end
            end
            CMD_SET_TGT:
            begin
                emit = idx_match;
                hit  = idx_match;
                if (idx_match)
                begin
                    tgt_next = word_reg.value;
                end
            end
            CMD_SET_CHAN:
            begin
                emit = idx_match;
                hit  = idx_match;
                if (idx_match)
                begin
                    tag_next = word_reg.chan;
                end
            end
            CMD_AUTO, CMD_MANUAL:
            begin
                emit  = 1'b1;
                sweep = 1'b1;
                hit   = (tag_reg == word_reg.chan);
                if (hit)
                begin
                    cur_next = moved;
                end
            end
            CMD_IDX_DAMP:
            begin
                emit = idx_match;
                hit  = idx_match;
                if (idx_match)
                begin
                    cur_next = moved;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
        if (!word_reg.tok)
        begin
            cur_next = cur_reg;
            tgt_next = tgt_reg;
            tag_next = tag_reg;
            emit     = 1'b0;
        end
    end

    always_comb
    begin
        result.valid     = emit;
        result.index     = IDX_W'(CELL_INDEX);
        result.position  = cur_next;
        result.at_target = (cur_next == tgt_next);
        result.hit       = hit;
        result.last      = sweep ? IS_LAST : 1'b1;
    end

    assign word_out = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg  <= '0;
            cur_reg   <= '0;
            tgt_reg   <= '0;
            tag_reg   <= '0;
            astep_reg <= ASTEP_W'(1);
        end
        else
        begin
            word_reg  <= word_in;
            cur_reg   <= cur_next;
            tgt_reg   <= tgt_next;
            tag_reg   <= tag_next;
            astep_reg <= astep_next;
        end
    end

endmodule

// ===== test/cspt_slew_checker.sv =====
// ----------------------------------------------------------------------------
// cspt_slew_checker
// Watches the command and result ports of the channel slew position table,
// keeps its own copy of the position table, works out the result words that
// each accepted command must produce and compares every result word, field
// by field, against the oldest one still owed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cspt_slew_checker #(
    parameter int ENTRIES = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic                                   busy,
    input  logic [2:0]                             command,
    input  logic [cspt_pkg::IDX_W-1:0]             entry_index,
    input  logic signed [cspt_pkg::POS_W-1:0]      position_value,
    input  logic [cspt_pkg::CHAN_W-1:0]            channel_id,
    input  logic [cspt_pkg::STEP_W-1:0]            step_size,
    input  logic                                   result_valid,
    input  logic [cspt_pkg::IDX_W-1:0]             out_index,
    input  logic signed [cspt_pkg::POS_W-1:0]      out_position,
    input  logic                                   at_target,
    input  logic                                   channel_hit,
    input  logic                                   last,
    output int                                     fail_count,
    output int                                     pending
);

    import cspt_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0]        index;
        logic signed [POS_W-1:0] position;
        logic                    at_tgt;
        logic                    hit;
        logic                    last;
    } table_word_t;

    logic signed [POS_W-1:0] cur_pos [ENTRIES];
    logic signed [POS_W-1:0] tgt_pos [ENTRIES];
    logic [CHAN_W-1:0]       chan_tag [ENTRIES];

    table_word_t owed_words [$];
    int          mismatches = 0;
    int          owed_count = 0;

    assign fail_count = mismatches;
    assign pending    = owed_count;

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("mismatch at %0t ns: %s got %0d want %0d", $time, what, got, want);
    endtask

    task automatic owe_word(input int i, input logic hit, input logic is_last);
        table_word_t w;
        w.index    = i[IDX_W-1:0];
        w.position = cur_pos[i];
        w.at_tgt   = (cur_pos[i] == tgt_pos[i]);
        w.hit      = hit;
        w.last     = is_last;
        owed_words.push_back(w);
    endtask

    // move toward target by stride, snap when within reach
    task automatic slew_entry(input int i, input int stride);
        int c;
        int t;
        c = cur_pos[i];
        t = tgt_pos[i];
        if (t > c + stride)
            cur_pos[i] = POS_W'(c + stride);
        else if (t < c - stride)
            cur_pos[i] = POS_W'(c - stride);
        else
            cur_pos[i] = tgt_pos[i];
    endtask

    task automatic predict_command();
        int i;
        int gap;
        logic hit;
        case (command)
            CMD_AUTO, CMD_MANUAL:
            begin
                for (i = 0; i < ENTRIES; i++)
                begin
                    hit = (chan_tag[i] == channel_id);
                    if (hit)
                    begin
                        if (command == CMD_AUTO)
                        begin
                            gap = int'(tgt_pos[i]) - int'(cur_pos[i]);
                            if (gap < 0)
                                gap = -gap;
                            slew_entry(i, gap / 20 + 1);
                        end
                        else
                            slew_entry(i, int'(step_size));
                    end
                    owe_word(i, hit, i == ENTRIES - 1);
                end
            end
            CMD_SET_CUR, CMD_SET_TGT, CMD_SET_CHAN, CMD_IDX_DAMP:
            begin
                if (int'(entry_index) < ENTRIES)
                begin
                    i = entry_index;
                    case (command)
                        CMD_SET_CUR:  cur_pos[i] = position_value;
                        CMD_SET_TGT:  tgt_pos[i] = position_value;
                        CMD_SET_CHAN: chan_tag[i] = channel_id;
                        default:      slew_entry(i, int'(step_size));
                    endcase
                    owe_word(i, 1'b1, 1'b1);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk)
    begin
        table_word_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                cur_pos[i]  = '0;
                tgt_pos[i]  = '0;
                chan_tag[i] = '0;
            end
            owed_words.delete();
            owed_count <= 0;
        end
        else
        begin
            if (result_valid)
            begin
                if (owed_words.size() == 0)
                    report_mismatch("result word with nothing owed, index", out_index, -1);
                else
                begin
                    want = owed_words.pop_front();
                    if (out_index !== want.index)
                        report_mismatch("out_index", out_index, want.index);
                    if (out_position !== want.position)
                        report_mismatch("out_position", int'(out_position),
                                        int'(want.position));
                    if (at_target !== want.at_tgt)
                        report_mismatch("at_target", at_target, want.at_tgt);
                    if (channel_hit !== want.hit)
                        report_mismatch("channel_hit", channel_hit, want.hit);
                    if (last !== want.last)
                        report_mismatch("last", last, want.last);
                end
            end
            if (start && !busy)
                predict_command();
            owed_count <= owed_words.size();
        end
    end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the channel slew position table with a directed set of commands
// covering extreme positions, steps and channel tags, then with random
// command streams under changing sender gaps; a checker beside the block
// predicts and compares every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import cspt_pkg::*;

    localparam int          ENTRIES       = 16;
    localparam int          QUIET_LIMIT   = 2000;
    localparam int          PHASE_WORDS   = 94;
    localparam logic [2:0]  CMD_SPARE_LO  = 3'd6;
    localparam logic [2:0]  CMD_SPARE_HI  = 3'd7;

    logic                   clk            = 1'b0;
    logic                   rst_n          = 1'b0;
    logic                   start          = 1'b0;
    logic                   busy;
    logic [2:0]             command        = '0;
    logic [IDX_W-1:0]       entry_index    = '0;
    logic signed [POS_W-1:0] position_value = '0;
    logic [CHAN_W-1:0]      channel_id     = '0;
    logic [STEP_W-1:0]      step_size      = '0;
    logic                   result_valid;
    logic [IDX_W-1:0]       out_index;
    logic signed [POS_W-1:0] out_position;
    logic                   at_target;
    logic                   channel_hit;
    logic                   last;

    int                     fail_count;
    int                     pending;
    int                     idle_pct       = 0;
    int                     quiet_cycles   = 0;
    logic [CHAN_W-1:0]      chan_pool [4]  = '{8'h00, 8'h3C, 8'hA5, 8'hFF};

    always #4 clk = ~clk;

    channel_slew_position_table #(
        .ENTRIES(ENTRIES)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .command(command),
        .entry_index(entry_index),
        .position_value(position_value),
        .channel_id(channel_id),
        .step_size(step_size),
        .result_valid(result_valid),
        .out_index(out_index),
        .out_position(out_position),
        .at_target(at_target),
        .channel_hit(channel_hit),
        .last(last)
    );

    cspt_slew_checker #(
        .ENTRIES(ENTRIES)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .command(command),
        .entry_index(entry_index),
        .position_value(position_value),
        .channel_id(channel_id),
        .step_size(step_size),
        .result_valid(result_valid),
        .out_index(out_index),
        .out_position(out_position),
        .at_target(at_target),
        .channel_hit(channel_hit),
        .last(last),
        .fail_count(fail_count),
        .pending(pending)
    );

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("** channel_slew_position_table: FAILED **");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // start drops at random on idle_pct percent of cycles until the word is taken
    task automatic send_word(input logic [2:0] cmd, input logic [IDX_W-1:0] idx,
                             input logic signed [POS_W-1:0] val,
                             input logic [CHAN_W-1:0] chan,
                             input logic [STEP_W-1:0] step);
        command        <= cmd;
        entry_index    <= idx;
        position_value <= val;
        channel_id     <= chan;
        step_size      <= step;
        forever
        begin
            start <= (int'($urandom_range(99)) >= idle_pct);
            @(posedge clk);
            if (start && !busy)
                break;
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (busy || pending != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [POS_W-1:0] pick_position();
        case ($urandom_range(5))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return POS_W'(int'($urandom_range(200)) - 100);
            default: return POS_W'($urandom_range(16'hFFFF));
        endcase
    endfunction

    function automatic logic [STEP_W-1:0] pick_step();
        case ($urandom_range(5))
            0:       return '0;
            1:       return 15'h7FFF;
            2, 3:    return STEP_W'($urandom_range(64));
            default: return STEP_W'($urandom_range(15'h7FFF));
        endcase
    endfunction

    function automatic logic [CHAN_W-1:0] pick_channel();
        if ($urandom_range(3) == 0)
            return CHAN_W'($urandom_range(255));
        return chan_pool[$urandom_range(3)];
    endfunction

    initial
    begin
        int counted;
        int roll;
        logic [2:0] cmd;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, zero step, no-match channel, spare codes
        send_word(CMD_SET_CHAN, 4'd5,  16'sd0,      8'hA5, 15'd0);
        send_word(CMD_SET_CHAN, 4'd15, 16'sd0,      8'hFF, 15'd0);
        send_word(CMD_SET_CUR,  4'd0,  16'sh8000,   8'h00, 15'd0);
        send_word(CMD_SET_TGT,  4'd0,  16'sh7FFF,   8'h00, 15'd0);
        send_word(CMD_SET_CUR,  4'd15, 16'sh7FFF,   8'h00, 15'd0);
        send_word(CMD_SET_TGT,  4'd15, 16'sh8000,   8'h00, 15'd0);
        send_word(CMD_AUTO,     4'd0,  16'sd0,      8'h00, 15'd0);
        send_word(CMD_MANUAL,   4'd0,  16'sd0,      8'h00, 15'h7FFF);
        send_word(CMD_MANUAL,   4'd0,  16'sd0,      8'h00, 15'h7FFF);
        send_word(CMD_SET_TGT,  4'd3,  16'sd100,    8'h00, 15'd0);
        send_word(CMD_MANUAL,   4'd7,  16'sh7FFF,   8'h00, 15'd0);
        send_word(CMD_IDX_DAMP, 4'd15, 16'sd0,      8'hFF, 15'd0);
        send_word(CMD_IDX_DAMP, 4'd15, 16'sd0,      8'hFF, 15'd1);
        send_word(CMD_MANUAL,   4'd15, 16'sd0,      8'hFF, 15'h7FFF);
        send_word(CMD_IDX_DAMP, 4'd15, 16'sd0,      8'h00, 15'h7FFF);
        send_word(CMD_AUTO,     4'd0,  16'sd0,      8'hA5, 15'd0);
        send_word(CMD_SPARE_LO, 4'd2,  16'sh7FFF,   8'h00, 15'h7FFF);
        send_word(CMD_SPARE_HI, 4'd15, 16'sh8000,   8'hFF, 15'h7FFF);
        send_word(CMD_SET_CUR,  4'd5,  -16'sd1,     8'h00, 15'd0);
        send_word(CMD_AUTO,     4'd0,  16'sd0,      8'h5A, 15'd0);
        send_word(CMD_AUTO,     4'd0,  16'sd0,      8'h00, 15'd0);
        send_word(CMD_IDX_DAMP, 4'd3,  16'sd0,      8'h00, 15'h7FFF);
        send_word(CMD_IDX_DAMP, 4'd5,  16'sd0,      8'h00, 15'd0);
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 24 : (phase == 1) ? 48 : 0;
            counted = 0;
            while (counted < PHASE_WORDS)
            begin
                roll = $urandom_range(99);
                if (roll < 16)
                    cmd = CMD_SET_CUR;
                else if (roll < 32)
                    cmd = CMD_SET_TGT;
                else if (roll < 44)
                    cmd = CMD_SET_CHAN;
                else if (roll < 62)
                    cmd = CMD_AUTO;
                else if (roll < 80)
                    cmd = CMD_MANUAL;
                else if (roll < 96)
                    cmd = CMD_IDX_DAMP;
                else
                    cmd = ($urandom_range(1) != 0) ? CMD_SPARE_HI : CMD_SPARE_LO;
                send_word(cmd, IDX_W'($urandom_range(ENTRIES - 1)), pick_position(),
                          pick_channel(), pick_step());
                if (cmd != CMD_SPARE_LO && cmd != CMD_SPARE_HI)
                    counted++;
            end
            drain();
        end

        repeat (ENTRIES + 4) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("** channel_slew_position_table: PASSED **");
        else
            $display("** channel_slew_position_table: FAILED **");
        $finish;
    end

endmodule
